// File: hw/rtl/vpf_pkg.sv
// Shared types, codes and helpers of the vector path flattener.
package vpf_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int OP_WIDTH        = 4;
  localparam int CFG_WIDTH       = 7;
  localparam int MAX_STEPS_DEF   = 64;
  localparam logic [CFG_WIDTH-1:0] STEPS_RESET = 7'd16;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH+1:0] coord_wide_t;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_CLOSE  = 4'd0,
    OP_MOVE   = 4'd1,
    OP_LINE   = 4'd2,
    OP_HLINE  = 4'd3,
    OP_VLINE  = 4'd4,
    OP_QUAD   = 4'd5,
    OP_CUBIC  = 4'd6,
    OP_SMOOTH = 4'd7,
    OP_END    = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_VERTEX = 2'd1,
    EV_END    = 2'd2,
    EV_ERROR  = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    SRC_CUR,
    SRC_LINE,
    SRC_CURVE,
    SRC_ZERO
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ENDMARK,
    ST_POINT,
    ST_ERR,
    ST_SETUP,
    ST_LOAD,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ROT,
    ST_CURVE_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic emit;
    ev_t  emit_kind;
    src_t src;
    logic last;
    logic setup;
    logic load;
    logic axis;
    logic mul;
    logic div_start;
    logic shift;
    logic shift_res;
    logic k_inc;
    logic update;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic contour_open;
    logic out_free;
    logic div_done;
    logic k_last;
  } status_t;

  // Clamp a widened sum to the signed coordinate range.
  function automatic coord_t sat_coord(input coord_wide_t v);
    coord_t res;
    if ((v[COORD_WIDTH+1:COORD_WIDTH-1] == 3'b000) ||
        (v[COORD_WIDTH+1:COORD_WIDTH-1] == 3'b111)) begin
      res = v[COORD_WIDTH-1:0];
    end else if (v[COORD_WIDTH+1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/vpf_if.sv
// Valid/ready channel interfaces for path segments and flattened results.
interface vpf_in_if import vpf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic       relative;
  coord_t     first_x;
  coord_t     first_y;
  coord_t     second_x;
  coord_t     second_y;
  coord_t     third_x;
  coord_t     third_y;

  modport source (output valid, operation, relative, first_x, first_y,
                  second_x, second_y, third_x, third_y, input ready);
  modport sink   (input valid, operation, relative, first_x, first_y,
                  second_x, second_y, third_x, third_y, output ready);
endinterface

interface vpf_out_if import vpf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  coord_t     vertex_x;
  coord_t     vertex_y;
  logic       last;

  modport source (output valid, event_res, vertex_x, vertex_y, last, input ready);
  modport sink   (input valid, event_res, vertex_x, vertex_y, last, output ready);
endinterface

// File: hw/rtl/vpf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module vpf_div #(
  parameter int DW = 40,
  parameter int NW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   div_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [NW:0]     trial;
  logic [NW:0]     diff;
  logic            ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNTW'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= CNTW'(DW);
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[NW-1:0] : trial[NW-1:0];
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/vpf_dp.sv
// Datapath: path state, operand capture, de Casteljau scratch and result register.
module vpf_dp import vpf_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  input  logic                 in_accept,
  input  logic [OP_WIDTH-1:0]  in_operation,
  input  logic                 in_relative,
  input  coord_t               in_first_x,
  input  coord_t               in_first_y,
  input  coord_t               in_second_x,
  input  coord_t               in_second_y,
  input  coord_t               in_third_x,
  input  coord_t               in_third_y,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_event_res,
  output coord_t               out_vertex_x,
  output coord_t               out_vertex_y,
  output logic                 out_last
);

  localparam int KW = $clog2(MAX_STEPS + 1);
  localparam int DW = COORD_WIDTH + KW + 1;
  localparam int PW = COORD_WIDTH + KW + 2;
  localparam int CW = COORD_WIDTH;

  logic [CFG_WIDTH-1:0] steps_r;
  coord_t               cur_x_r, cur_y_r, ctl_x_r, ctl_y_r;
  logic                 open_r;
  op_t                  op_r;
  coord_t               c_r [6];
  coord_t               px_r [4];
  coord_t               py_r [4];
  coord_t               s_r [4];
  coord_t               vx_r;
  coord_t               a_r;
  logic signed [PW-1:0] prod_r;
  logic [KW-1:0]        k_r;
  logic                 out_valid_r;
  ev_t                  ev_r;
  coord_t               ox_r, oy_r;
  logic                 last_r;

  logic [KW-1:0]        ns;
  logic [KW-1:0]        half;
  coord_t               off_x, off_y;
  coord_t               fld [6];
  coord_t               c_nxt [6];
  coord_t               line_x, line_y;
  coord_t               refl_x, refl_y;
  logic signed [CW:0]   diff;
  logic signed [PW-1:0] prod_nxt;
  logic [PW-1:0]        mag;
  logic [DW-1:0]        dividend;
  logic                 div_done;
  logic [DW-1:0]        quotient;
  coord_wide_t          qs;
  coord_wide_t          res_w;
  coord_t               res;
  coord_t               emit_x, emit_y;
  ev_t                  emit_ev;
  logic                 out_free;

  // Clamp the configured step count into 1..MAX_STEPS.
  always_comb begin
    if (steps_r == '0) begin
      ns = KW'(1);
    end else if (int'(steps_r) > MAX_STEPS) begin
      ns = KW'(MAX_STEPS);
    end else begin
      ns = KW'(steps_r);
    end
    half = ns >> 1;
  end

  assign fld[0] = in_first_x;
  assign fld[1] = in_first_y;
  assign fld[2] = in_second_x;
  assign fld[3] = in_second_y;
  assign fld[4] = in_third_x;
  assign fld[5] = in_third_y;
  assign off_x  = in_relative ? cur_x_r : '0;
  assign off_y  = in_relative ? cur_y_r : '0;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      c_nxt[i] = sat_coord(coord_wide_t'(fld[i]) +
                           coord_wide_t'(((i % 2) == 1) ? off_y : off_x));
    end
  end

  assign line_x = (op_r == OP_VLINE) ? cur_x_r : c_r[0];
  assign line_y = (op_r == OP_HLINE) ? cur_y_r : c_r[1];
  assign refl_x = sat_coord((coord_wide_t'(cur_x_r) <<< 1) - coord_wide_t'(ctl_x_r));
  assign refl_y = sat_coord((coord_wide_t'(cur_y_r) <<< 1) - coord_wide_t'(ctl_y_r));

  // One interpolation: (b - a) * k, rounded divide by ns, add back a.
  assign diff     = {s_r[1][CW-1], s_r[1]} - {s_r[0][CW-1], s_r[0]};
  assign prod_nxt = PW'(diff) * PW'($signed({1'b0, k_r}));
  assign mag      = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  assign dividend = mag[DW-1:0] + DW'(half);

  vpf_div #(.DW(DW), .NW(KW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (ns),
    .done     (div_done),
    .quotient (quotient)
  );

  assign qs    = prod_r[PW-1] ? -coord_wide_t'({1'b0, quotient[CW:0]})
                              : coord_wide_t'({1'b0, quotient[CW:0]});
  assign res_w = coord_wide_t'(a_r) + qs;
  assign res   = res_w[CW-1:0];

  always_comb begin
    case (cmd.src)
      SRC_CUR:   begin emit_x = cur_x_r; emit_y = cur_y_r; end
      SRC_LINE:  begin emit_x = line_x;  emit_y = line_y;  end
      SRC_CURVE: begin emit_x = vx_r;    emit_y = s_r[0];  end
      default:   begin emit_x = '0;      emit_y = '0;      end
    endcase
    case (cmd.emit_kind)
      EV_VERTEX: emit_ev = open_r ? EV_VERTEX : EV_START;
      EV_END:    emit_ev = EV_END;
      EV_ERROR:  emit_ev = EV_ERROR;
      default:   emit_ev = EV_START;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= STEPS_RESET;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      ctl_x_r     <= '0;
      ctl_y_r     <= '0;
    end else begin
      if (cfg_we) begin
        steps_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (cmd.emit_kind == EV_END) begin
          open_r <= 1'b0;
        end else if (cmd.emit_kind == EV_VERTEX) begin
          open_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.update) begin
        case (op_r)
          OP_CLOSE: begin
            ctl_x_r <= cur_x_r;
            ctl_y_r <= cur_y_r;
          end
          OP_MOVE, OP_LINE, OP_HLINE, OP_VLINE: begin
            cur_x_r <= line_x; cur_y_r <= line_y;
            ctl_x_r <= line_x; ctl_y_r <= line_y;
          end
          OP_QUAD, OP_SMOOTH: begin
            ctl_x_r <= c_r[0]; ctl_y_r <= c_r[1];
            cur_x_r <= c_r[2]; cur_y_r <= c_r[3];
          end
          OP_CUBIC: begin
            ctl_x_r <= c_r[2]; ctl_y_r <= c_r[3];
            cur_x_r <= c_r[4]; cur_y_r <= c_r[5];
          end
          OP_END: begin
            cur_x_r <= '0; cur_y_r <= '0;
            ctl_x_r <= '0; ctl_y_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Operand and working registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= op_t'(in_operation);
      for (int i = 0; i < 6; i++) begin
        c_r[i] <= c_nxt[i];
      end
    end
    if (cmd.setup) begin
      k_r     <= KW'(1);
      px_r[0] <= cur_x_r;
      py_r[0] <= cur_y_r;
      if (op_r == OP_SMOOTH) begin
        px_r[1] <= refl_x; py_r[1] <= refl_y;
        px_r[2] <= c_r[0]; py_r[2] <= c_r[1];
        px_r[3] <= c_r[2]; py_r[3] <= c_r[3];
      end else begin
        px_r[1] <= c_r[0]; py_r[1] <= c_r[1];
        px_r[2] <= c_r[2]; py_r[2] <= c_r[3];
        px_r[3] <= (op_r == OP_QUAD) ? c_r[2] : c_r[4];
        py_r[3] <= (op_r == OP_QUAD) ? c_r[3] : c_r[5];
      end
    end else if (cmd.k_inc) begin
      k_r <= k_r + KW'(1);
    end
    if (cmd.load) begin
      if (cmd.axis) begin
        vx_r <= s_r[0];
      end
      for (int i = 0; i < 4; i++) begin
        s_r[i] <= cmd.axis ? py_r[i] : px_r[i];
      end
    end else if (cmd.shift) begin
      s_r[0] <= s_r[1];
      s_r[1] <= s_r[2];
      s_r[2] <= s_r[3];
      s_r[3] <= cmd.shift_res ? res : s_r[0];
    end
    if (cmd.mul) begin
      a_r    <= s_r[0];
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      ev_r   <= emit_ev;
      ox_r   <= emit_x;
      oy_r   <= emit_y;
      last_r <= cmd.last;
    end
  end

  assign sts.op           = op_r;
  assign sts.contour_open = open_r;
  assign sts.out_free     = out_free;
  assign sts.div_done     = div_done;
  assign sts.k_last       = (k_r == ns);

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_vertex_x  = ox_r;
  assign out_vertex_y  = oy_r;
  assign out_last      = last_r;

endmodule

// File: hw/rtl/vpf_ctrl.sv
// Controller: segment dispatch and the interpolation sequence per vertex.
module vpf_ctrl import vpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic       axis_r, axis_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [1:0] j_r, j_nxt;
  logic [1:0] deg;
  logic [2:0] m;
  logic       adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
      lvl_r   <= 2'd1;
      j_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      lvl_r   <= lvl_nxt;
      j_r     <= j_nxt;
    end
  end

  assign deg = (sts.op == OP_QUAD) ? 2'd2 : 2'd3;
  assign m   = {1'b0, deg} - {1'b0, lvl_r} + 3'd1;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    cmd           = '0;
    cmd.emit_kind = EV_VERTEX;
    cmd.src       = SRC_ZERO;
    in_ready      = 1'b0;
    adv           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_CLOSE, OP_END: state_nxt = sts.contour_open ? ST_ENDMARK : ST_FINISH;
          OP_MOVE:          state_nxt = sts.contour_open ? ST_ENDMARK : ST_POINT;
          OP_LINE, OP_HLINE, OP_VLINE: state_nxt = ST_POINT;
          OP_QUAD, OP_CUBIC, OP_SMOOTH: state_nxt = ST_SETUP;
          default:          state_nxt = ST_ERR;
        endcase
      end
      ST_ENDMARK: begin
        cmd.emit_kind = EV_END;
        cmd.src       = SRC_CUR;
        cmd.last      = (sts.op != OP_MOVE);
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = (sts.op == OP_MOVE) ? ST_POINT : ST_FINISH;
        end
      end
      ST_POINT: begin
        cmd.src  = SRC_LINE;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_ERR: begin
        cmd.emit_kind = EV_ERROR;
        cmd.last      = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        axis_nxt  = 1'b0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cmd.axis  = axis_r;
        lvl_nxt   = 2'd1;
        j_nxt     = 2'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.shift     = 1'b1;
          cmd.shift_res = 1'b1;
          adv           = 1'b1;
        end
      end
      ST_ROT: begin
        cmd.shift = 1'b1;
        adv       = 1'b1;
      end
      ST_CURVE_EMIT: begin
        cmd.src  = SRC_CURVE;
        cmd.last = sts.k_last;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.k_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.k_inc = 1'b1;
            axis_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_FINISH: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Each level rotates the four scratch slots once round.
    if (adv) begin
      if (j_r == 2'd3) begin
        if (lvl_r == deg) begin
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_CURVE_EMIT;
          end
        end else begin
          lvl_nxt   = lvl_r + 2'd1;
          j_nxt     = 2'd0;
          state_nxt = ST_MUL;
        end
      end else begin
        j_nxt     = j_r + 2'd1;
        state_nxt = (({1'b0, j_r} + 3'd1) < m) ? ST_MUL : ST_ROT;
      end
    end
  end

endmodule

// File: hw/rtl/vector_path_flattener.sv
// Vector path flattener: path segments in, contour markers and polyline vertices out.
// Flow: an accepted segment passes a dispatch state before its first result is registered
// (a move that ends a contour gives its vertex after the end marker); no new segment is
// taken until the last is done. Curves: per vertex, de Casteljau per axis on one shared
// interpolator (restoring divider).
// Reset (synchronous, active low) clears points, contour flag, result; steps set to 16.
module vector_path_flattener import vpf_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  vpf_in_if.sink               in_ch,
  vpf_out_if.source            out_ch
);

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;
  logic    in_accept;

  // An item is taken only when the controller is idle; a waiting result
  // does not hold that up, as the result register parts the two sides.
  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  vpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the current point, control point and contour flag,
  // samples curves through the shared interpolator and drives the result
  // register for each transfer.
  vpf_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_accept     (in_accept),
    .in_operation  (in_ch.operation),
    .in_relative   (in_ch.relative),
    .in_first_x    (in_ch.first_x),
    .in_first_y    (in_ch.first_y),
    .in_second_x   (in_ch.second_x),
    .in_second_y   (in_ch.second_y),
    .in_third_x    (in_ch.third_x),
    .in_third_y    (in_ch.third_y),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_event_res (out_ch.event_res),
    .out_vertex_x  (out_ch.vertex_x),
    .out_vertex_y  (out_ch.vertex_y),
    .out_last      (out_ch.last)
  );

endmodule

// File: hw/rtl/vpf_checker.sv
// Port checker for the flattener result channel, bound to the top level.
module vpf_checker import vpf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event,
  input coord_t     out_x,
  input coord_t     out_y,
  input logic       out_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_event))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event == EV_ERROR) |-> (out_x == '0) && (out_y == '0))
    else $error("error result with non-zero coordinates");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event == EV_ERROR) |-> out_last)
    else $error("error result not marked last");

endmodule

bind vector_path_flattener vpf_checker u_vpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_event (out_ch.event_res),
  .out_x     (out_ch.vertex_x),
  .out_y     (out_ch.vertex_y),
  .out_last  (out_ch.last)
);

// File: dv/tb_vector_path_flattener.sv
// Self-checking testbench of the vector path flattener: directed table, then random paths.
module tb_vector_path_flattener;
  import vpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block does not support; both ends of the free range are used.
  localparam logic [3:0] OP_BAD_LO = 4'd9;
  localparam logic [3:0] OP_BAD_HI = 4'd15;
  localparam int         SETTLE    = 20;     // idle cycles before a register write
  localparam int         LONG_HOLD = 400;    // receiver hold-off used to back the block up

  typedef struct {
    logic [3:0] op;
    logic       rel;
    coord_t     v[6];    // first_x, first_y, second_x, second_y, third_x, third_y
  } segment_t;

  typedef struct {
    ev_t    ev;
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_res_t;

  // Directed row: tn < 0 means check against the predictor, otherwise the
  // row expects tn results (0 or 1) typed in below.
  typedef struct {
    segment_t seg;
    int       tn;
    ev_t      tev;
    coord_t   tx;
    coord_t   ty;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  vpf_in_if  in_ch ();
  vpf_out_if out_ch ();

  vector_path_flattener u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state, mirrors the block's point registers and contour flag.
  longint               cur_x, cur_y, ctl_x, ctl_y;
  bit                   open_contour;
  logic [CFG_WIDTH-1:0] steps_reg;

  vertex_res_t pending_vertices[$];   // expected results, oldest first
  vertex_res_t seg_results[$];        // scratch for one segment

  int  mismatches, strays, results_seen, segments_sent, settings_seen;
  bit  hold_req;       // ask the receiver for one long hold-off
  bit  quiet_phase;    // no idling on either side while set
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #250ms;
    $display("Timeout: %0d results still expected", pending_vertices.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp to the signed 32-bit Q16.16 range.
  function automatic longint clamp_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // a + (b - a) * k / n, rounded to nearest, ties away from zero.
  function automatic longint interp(longint a, longint b, longint k, longint n);
    longint prod, half, q;
    prod = (b - a) * k;
    half = n / 2;
    q = (prod >= 0) ? (prod + half) / n : -((-prod + half) / n);
    return a + q;
  endfunction

  function automatic longint quad_point(longint p0, longint p1, longint p2,
                                        longint k, longint n);
    return interp(interp(p0, p1, k, n), interp(p1, p2, k, n), k, n);
  endfunction

  function automatic longint cubic_point(longint p0, longint p1, longint p2, longint p3,
                                         longint k, longint n);
    longint a, b, c;
    a = interp(p0, p1, k, n);
    b = interp(p1, p2, k, n);
    c = interp(p2, p3, k, n);
    return interp(interp(a, b, k, n), interp(b, c, k, n), k, n);
  endfunction

  function automatic void note_result(ev_t ev, longint x, longint y);
    vertex_res_t r;
    r.ev   = ev;
    r.x    = coord_t'(x);
    r.y    = coord_t'(y);
    r.last = 1'b0;
    seg_results = {seg_results, r};
  endfunction

  // A drawn vertex opens the contour if none is open.
  function automatic void note_vertex(longint x, longint y);
    note_result(open_contour ? EV_VERTEX : EV_START, x, y);
    open_contour = 1'b1;
  endfunction

  // Work out the results of one segment into seg_results and advance the state.
  function automatic void flatten_segment(segment_t s);
    longint c[6];
    longint n, k, lx, ly, p1x, p1y, p2x, p2y, ex, ey;
    seg_results.delete();
    for (int i = 0; i < 6; i++) begin
      c[i] = clamp_q16(longint'(s.v[i]) + (s.rel ? ((i % 2) ? cur_y : cur_x) : 0));
    end
    n = steps_reg;
    if (n < 1) n = 1;
    if (n > MAX_STEPS_DEF) n = MAX_STEPS_DEF;
    case (s.op)
      OP_CLOSE: begin
        if (open_contour) note_result(EV_END, cur_x, cur_y);
        open_contour = 1'b0;
        ctl_x = cur_x;
        ctl_y = cur_y;
      end
      OP_MOVE: begin
        if (open_contour) note_result(EV_END, cur_x, cur_y);
        open_contour = 1'b0;
        note_vertex(c[0], c[1]);
        cur_x = c[0]; ctl_x = c[0];
        cur_y = c[1]; ctl_y = c[1];
      end
      OP_LINE, OP_HLINE, OP_VLINE: begin
        lx = (s.op == OP_VLINE) ? cur_x : c[0];
        ly = (s.op == OP_HLINE) ? cur_y : c[1];
        note_vertex(lx, ly);
        cur_x = lx; ctl_x = lx;
        cur_y = ly; ctl_y = ly;
      end
      OP_QUAD: begin
        for (k = 1; k <= n; k++)
          note_vertex(quad_point(cur_x, c[0], c[2], k, n), quad_point(cur_y, c[1], c[3], k, n));
        ctl_x = c[0]; ctl_y = c[1];
        cur_x = c[2]; cur_y = c[3];
      end
      OP_CUBIC, OP_SMOOTH: begin
        if (s.op == OP_CUBIC) begin
          p1x = c[0]; p1y = c[1]; p2x = c[2]; p2y = c[3]; ex = c[4]; ey = c[5];
        end else begin
          // mirror the stored control point through the current point
          p1x = clamp_q16(2 * cur_x - ctl_x);
          p1y = clamp_q16(2 * cur_y - ctl_y);
          p2x = c[0]; p2y = c[1]; ex = c[2]; ey = c[3];
        end
        for (k = 1; k <= n; k++)
          note_vertex(cubic_point(cur_x, p1x, p2x, ex, k, n),
                      cubic_point(cur_y, p1y, p2y, ey, k, n));
        ctl_x = p2x; ctl_y = p2y;
        cur_x = ex;  cur_y = ey;
      end
      OP_END: begin
        if (open_contour) note_result(EV_END, cur_x, cur_y);
        open_contour = 1'b0;
        cur_x = 0; cur_y = 0; ctl_x = 0; ctl_y = 0;
      end
      default: note_result(EV_ERROR, 0, 0);
    endcase
    if (seg_results.size() > 0) seg_results[seg_results.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one segment and hold it until the transfer; valid stays high after.
  task automatic send_segment(segment_t s, int tn, vertex_res_t typed);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= s.op;
    in_ch.relative  <= s.rel;
    in_ch.first_x   <= s.v[0];
    in_ch.first_y   <= s.v[1];
    in_ch.second_x  <= s.v[2];
    in_ch.second_y  <= s.v[3];
    in_ch.third_x   <= s.v[4];
    in_ch.third_y   <= s.v[5];
    do @(posedge clk); while (!in_ch.ready);
    segments_sent++;
    flatten_segment(s);
    if (tn >= 0) begin
      // typed expectation replaces the predicted one; the state still advances
      seg_results.delete();
      if (tn > 0) seg_results = {seg_results, typed};
    end
    pending_vertices = {pending_vertices, seg_results};
  endtask

  // Mostly short gaps, now and then a long one, none in a quiet phase.
  task automatic sender_gap();
    int gap;
    if (quiet_phase) return;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = 0;
      9:          gap = $urandom_range(15, 60);
      default:    gap = $urandom_range(1, 3);
    endcase
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come, then settle.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_steps(logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    steps_reg = val;
    settings_seen++;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  // Mostly drawing segments with random content, some noise codes.
  function automatic segment_t rand_segment(bit few_curves);
    segment_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      s.op = OP_MOVE;
    else if (pick < 25) s.op = OP_LINE;
    else if (pick < 31) s.op = OP_HLINE;
    else if (pick < 37) s.op = OP_VLINE;
    else if (pick < 47) s.op = few_curves ? OP_LINE : OP_QUAD;
    else if (pick < 59) s.op = few_curves ? OP_HLINE : OP_CUBIC;
    else if (pick < 69) s.op = few_curves ? OP_VLINE : OP_SMOOTH;
    else if (pick < 79) s.op = OP_CLOSE;
    else if (pick < 87) s.op = OP_END;
    else                s.op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    s.rel = 1'($urandom);
    foreach (s.v[i]) s.v[i] = rand_coord();
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      stall_left   <= LONG_HOLD;
      hold_req     <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare every transfer with the oldest expectation, field by field.
  always @(posedge clk) begin
    vertex_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_vertices.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10)
          $display("%0t: unexpected result ev=%0d x=%h y=%h last=%b", $realtime,
                   out_ch.event_res, out_ch.vertex_x, out_ch.vertex_y, out_ch.last);
      end else begin
        want = pending_vertices.pop_front();
        if (out_ch.event_res !== want.ev || out_ch.vertex_x !== want.x ||
            out_ch.vertex_y !== want.y || out_ch.last !== want.last) begin
          mismatches++;
          if (strays + mismatches <= 10)
            $display("%0t: mismatch ev=%0d/%0d x=%h/%h y=%h/%h last=%b/%b (got/expected)",
                     $realtime, out_ch.event_res, want.ev, out_ch.vertex_x, want.x,
                     out_ch.vertex_y, want.y, out_ch.last, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  function automatic directed_row_t row(logic [3:0] op, logic rel, coord_t fx, coord_t fy,
                                        coord_t sx, coord_t sy, coord_t tx3, coord_t ty3,
                                        int tn, ev_t tev, coord_t tx, coord_t ty);
    directed_row_t r;
    r.seg.op = op;
    r.seg.rel = rel;
    r.seg.v = '{fx, fy, sx, sy, tx3, ty3};
    r.tn = tn; r.tev = tev; r.tx = tx; r.ty = ty;
    return r;
  endfunction

  localparam coord_t QMAX = 32'sh7fffffff;
  localparam coord_t QMIN = 32'sh80000000;
  localparam coord_t ONE  = 32'sh00010000;

  directed_row_t directed_rows[$];

  // Append one row to the directed table.
  function automatic void add_row(directed_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  initial begin
    logic [CFG_WIDTH-1:0] phase_steps[9] = '{7'd1, 7'd0, 7'd64, 7'd3, 7'd127,
                                             7'd7, 7'd2, 7'd5, 7'd8};
    vertex_res_t typed;
    segment_t    s;
    int          count;

    // Hold every input at a known value from time zero.
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.relative = 1'b0;
    in_ch.first_x = '0;  in_ch.first_y = '0;
    in_ch.second_x = '0; in_ch.second_y = '0;
    in_ch.third_x = '0;  in_ch.third_y = '0;
    hold_req = 1'b0;
    quiet_phase = 1'b0;

    cur_x = 0; cur_y = 0; ctl_x = 0; ctl_y = 0;
    open_contour = 1'b0;
    steps_reg = STEPS_RESET;

    // Close and end path with nothing open give nothing; bad codes give an error.
    add_row(row(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0, EV_START, 0, 0));
    add_row(row(OP_END, 1, 0, 0, 0, 0, 0, 0, 0, EV_START, 0, 0));
    add_row(row(OP_BAD_LO, 0, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 1, EV_ERROR, 0, 0));
    add_row(row(OP_BAD_HI, 1, -1, -1, -1, -1, -1, -1, 1, EV_ERROR, 0, 0));
    add_row(row(OP_MOVE, 0, ONE, 2 * ONE, 0, 0, 0, 0, 1, EV_START, ONE, 2 * ONE));
    add_row(row(OP_LINE, 0, QMAX, QMIN, 0, 0, 0, 0, 1, EV_VERTEX, QMAX, QMIN));
    // relative sums saturate at both ends
    add_row(row(OP_LINE, 1, QMAX, QMIN, 0, 0, 0, 0, 1, EV_VERTEX, QMAX, QMIN));
    add_row(row(OP_HLINE, 0, 0, ONE, 0, 0, 0, 0, 1, EV_VERTEX, 0, QMIN));
    add_row(row(OP_VLINE, 1, 5 * ONE, ONE, 0, 0, 0, 0, 1, EV_VERTEX, 0, 32'sh80010000));
    add_row(row(OP_CLOSE, 1, 0, 0, 0, 0, 0, 0, 1, EV_END, 0, 32'sh80010000));
    // drawing with no contour open starts one
    add_row(row(OP_LINE, 0, 5 * ONE, 5 * ONE, 0, 0, 0, 0, 1, EV_START, 5 * ONE, 5 * ONE));
    add_row(row(OP_QUAD, 0, 9 * ONE, -3 * ONE, 20 * ONE, 7 * ONE, 0, 0,
                -1, EV_START, 0, 0));
    add_row(row(OP_CUBIC, 0, 30 * ONE, 30 * ONE, -10 * ONE, 40 * ONE, 3, -7,
                -1, EV_START, 0, 0));
    add_row(row(OP_SMOOTH, 0, 50 * ONE, 0, 60 * ONE, -20 * ONE, 0, 0, -1, EV_START, 0, 0));
    add_row(row(OP_CUBIC, 1, QMAX, QMIN, QMIN, QMAX, QMAX, QMAX, -1, EV_START, 0, 0));
    add_row(row(OP_SMOOTH, 1, QMIN, QMIN, QMIN, QMIN, 0, 0, -1, EV_START, 0, 0));
    add_row(row(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, -1, EV_START, 0, 0));
    add_row(row(OP_MOVE, 1, -ONE, 3, 0, 0, 0, 0, -1, EV_START, 0, 0));
    add_row(row(OP_QUAD, 1, QMIN, QMAX, ONE, -ONE, 0, 0, -1, EV_START, 0, 0));
    add_row(row(OP_END, 0, 0, 0, 0, 0, 0, 0, -1, EV_START, 0, 0));
    // smooth cubic straight after end path reflects through the origin
    add_row(row(OP_SMOOTH, 0, 4 * ONE, 8 * ONE, 12 * ONE, -ONE, 0, 0, -1, EV_START, 0, 0));
    add_row(row(OP_END, 0, 0, 0, 0, 0, 0, 0, -1, EV_START, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset setting of sixteen steps.
    foreach (directed_rows[i]) begin
      typed.ev   = directed_rows[i].tev;
      typed.x    = directed_rows[i].tx;
      typed.y    = directed_rows[i].ty;
      typed.last = 1'b1;
      send_segment(directed_rows[i].seg, directed_rows[i].tn, typed);
      sender_gap();
    end
    drain_block();

    // Random part: one phase per setting, the register written only when idle.
    foreach (phase_steps[p]) begin
      write_steps(phase_steps[p]);
      quiet_phase = (p == 3);
      // large step counts make curves long, so keep those phases short
      count = (phase_steps[p] >= 7'd64) ? 6 : 13;
      if (p == 5) hold_req = 1'b1;   // back the block up, sender keeps offering
      for (int j = 0; j < count; j++) begin
        s = rand_segment(1'b0);
        send_segment(s, -1, typed);
        if (p != 5) sender_gap();
      end
      drain_block();
    end
    quiet_phase = 1'b0;

    repeat (50) @(posedge clk);
    $display("Run covered %0d segments and %0d results over %0d step settings.",
             segments_sent, results_seen, settings_seen + 1);
    $display("Extremes, every opcode, saturation, reflection and long stalls were exercised.");
    if (mismatches == 0 && strays == 0 && pending_vertices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, strays,
               pending_vertices.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: vector_path_flattener.f
hw/rtl/vpf_pkg.sv
hw/rtl/vpf_if.sv
hw/rtl/vpf_div.sv
hw/rtl/vpf_dp.sv
hw/rtl/vpf_ctrl.sv
hw/rtl/vector_path_flattener.sv
hw/rtl/vpf_checker.sv
dv/tb_vector_path_flattener.sv
